// ----- src/first_fit_heap_allocator_macros.svh -----
// Assertion macros used by the allocator's RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ffha_pkg.sv -----
package ffha_pkg;

   // Request function codes.
   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_OOM     = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic        func;
      logic [15:0] request_bytes;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
      logic [15:0] used_bytes;
      logic [31:0] alloc_count;
   } rsp_type;

endpackage

// ----- src/first_fit_heap_allocator.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready   ffha_pkg::req_type
// rsp      out        rsp_valid / rsp_ready   ffha_pkg::rsp_type
//
// After reset the map is cleared one entry a cycle, taking no request.
// Each request first goes through a reciprocal multiply that turns bytes into granules.
// An allocate then reads and checks each block walked, up to the one taken, and splits it if large.
// A release reads and checks each follower merged and each block walked from offset zero to its
// predecessor, then folds into that predecessor if it is free.
// The response register holds one result; the next request is taken once it is read.
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator #(
   parameter int ARENA_BYTES   = 65536,
   parameter int HEADER_BYTES  = 32,
   parameter int GRANULE_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffha_pkg::rsp_type rsp_data
);

   localparam int GRANULES = ARENA_BYTES / GRANULE_BYTES;
   localparam int IDX_W    = $clog2(GRANULES);
   localparam int PW       = IDX_W + 1;
   localparam int HDR_G    = HEADER_BYTES / GRANULE_BYTES;
   localparam int ENT_W    = IDX_W + 2;
   localparam int GSH      = $clog2(GRANULE_BYTES);
   localparam int DVW      = GSH + 1;
   localparam int NW       = 17;
   localparam int CW       = ((PW > NW) ? PW : NW) + 1;
   localparam int RK       = 16 + GSH;
   localparam longint RECIP = ((longint'(1) << RK) + longint'(GRANULE_BYTES) - longint'(1))
                              / longint'(GRANULE_BYTES);

   localparam logic [CW-1:0]    GRAN_C   = CW'(GRANULES);
   localparam logic [CW-1:0]    HDR_C    = CW'(HDR_G);
   localparam logic [IDX_W-1:0] INIT_SZ  = IDX_W'(GRANULES - HDR_G);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRANULES - 1);
   localparam logic [16:0]      HDR_B    = 17'(HEADER_BYTES);
   localparam logic [17:0]      RECIP_C  = 18'(RECIP);
   localparam logic [15:0]      GRAN16   = 16'(GRANULE_BYTES);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_A_RD  = 4'd4;
   localparam logic [3:0] S_A_CHK = 4'd5;
   localparam logic [3:0] S_A_FIN = 4'd6;
   localparam logic [3:0] S_R_RD  = 4'd7;
   localparam logic [3:0] S_R_CHK = 4'd8;
   localparam logic [3:0] S_N_RD  = 4'd9;
   localparam logic [3:0] S_N_CHK = 4'd10;
   localparam logic [3:0] S_P_RD  = 4'd11;
   localparam logic [3:0] S_P_CHK = 4'd12;
   localparam logic [3:0] S_P_END = 4'd13;
   localparam logic [3:0] S_P_CLR = 4'd14;
   localparam logic [3:0] S_RESP  = 4'd15;

   // Block map: start flag, free flag, payload size in granules.
   logic [ENT_W-1:0] map_mem [GRANULES];

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   ffha_pkg::req_type req_ff, req_in;
   logic [15:0]       dvd_ff, dvd_in;
   logic [DVW-1:0]    rem_ff, rem_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [NW-1:0]     need_ff, need_in;
   logic [IDX_W-1:0]  bsize_ff, bsize_in;
   logic [PW-1:0]     q_ff, q_in;
   logic [PW-1:0]     prev_ff, prev_in;
   logic [IDX_W-1:0]  prev_size_ff, prev_size_in;
   logic              prev_free_ff, prev_free_in;
   logic              have_prev_ff, have_prev_in;
   logic [15:0]       used_ff, used_in;
   logic [31:0]       alloc_ff, alloc_in;
   ffha_pkg::rsp_type rsp_ff, rsp_in;
   logic [ENT_W-1:0]  rd_q_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic [IDX_W-1:0]  rd_addr;

   logic              req_fire;
   logic              rsp_oom;
   logic              in_clear;

   // Granule count to a byte count, kept to 16 bits.
   function automatic logic [15:0] gran_bytes(input logic [CW-1:0] g);
      logic [31:0] w;
      w = 32'(g) * 32'(GRANULE_BYTES);
      return w[15:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Sequencer: each state does at most one map write and one map read.
   always_comb begin
      logic [33:0]    div_prod;
      logic [33:0]    div_shift;
      logic [15:0]    div_q;
      logic [15:0]    div_back;
      logic [15:0]    div_rem;
      logic           e_start;
      logic           e_free;
      logic [CW-1:0]  e_size;
      logic [CW-1:0]  pos_w;
      logic [CW-1:0]  next_w;
      logic [CW-1:0]  sum_w;

      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      need_in      = need_ff;
      bsize_in     = bsize_ff;
      q_in         = q_ff;
      prev_in      = prev_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      have_prev_in = have_prev_ff;
      used_in      = used_ff;
      alloc_in     = alloc_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[IDX_W-1:0];
      wr_data      = '0;
      rd_addr      = pos_ff[IDX_W-1:0];

      div_prod  = '0;
      div_shift = '0;
      div_q     = '0;
      div_back  = '0;
      div_rem   = '0;
      e_start   = rd_q_ff[ENT_W-1];
      e_free    = rd_q_ff[ENT_W-2];
      e_size    = CW'(rd_q_ff[IDX_W-1:0]);
      pos_w     = CW'(pos_ff);
      next_w    = pos_w + HDR_C + CW'(bsize_ff);
      sum_w     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = (clr_cnt_ff == '0) ? {1'b1, 1'b1, INIT_SZ} : '0;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.func == ffha_pkg::FUNC_ALLOC) begin
                  dvd_in = (req_data.request_bytes == '0) ? 16'd0
                                                          : req_data.request_bytes - 16'd1;
               end else begin
                  dvd_in = req_data.release_offset;
               end
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Byte count to granules by a reciprocal multiply, exact for any 16-bit count.
            div_prod  = 34'(dvd_ff) * 34'(RECIP_C);
            div_shift = div_prod >> RK;
            div_q     = div_shift[15:0];
            div_back  = div_q * GRAN16;
            div_rem   = dvd_ff - div_back;
            dvd_in    = div_q;
            rem_in    = div_rem[DVW-1:0];
            state_in  = S_DEC;
         end
         S_DEC: begin
            // Quotient in dvd_ff, remainder in rem_ff.
            if (req_ff.func == ffha_pkg::FUNC_ALLOC) begin
               need_in  = NW'(dvd_ff) + NW'(1);
               pos_in   = '0;
               state_in = S_A_RD;
            end else begin
               sum_w = CW'(dvd_ff) - HDR_C;
               if (req_ff.release_offset == '0 || {1'b0, req_ff.release_offset} < HDR_B ||
                   rem_ff != '0 || sum_w >= GRAN_C) begin
                  rsp_in   = '{ffha_pkg::STATUS_IGNORED, 16'd0, used_ff, alloc_ff};
                  state_in = S_RESP;
               end else begin
                  pos_in   = sum_w[PW-1:0];
                  state_in = S_R_RD;
               end
            end
         end
         S_A_RD: begin
            if (pos_w >= GRAN_C) begin
               rsp_in   = '{ffha_pkg::STATUS_OOM, 16'd0, used_ff, alloc_ff};
               state_in = S_RESP;
            end else begin
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (!e_start) begin
               rsp_in   = '{ffha_pkg::STATUS_OOM, 16'd0, used_ff, alloc_ff};
               state_in = S_RESP;
            end else if (e_free && e_size >= CW'(need_ff)) begin
               if (e_size >= CW'(need_ff) + HDR_C + CW'(1)) begin
                  // Split: the remainder becomes a new free block.
                  sum_w    = pos_w + HDR_C + CW'(need_ff);
                  wr_en    = 1'b1;
                  wr_addr  = sum_w[IDX_W-1:0];
                  next_w   = e_size - CW'(need_ff) - HDR_C;
                  wr_data  = {1'b1, 1'b1, next_w[IDX_W-1:0]};
                  bsize_in = need_ff[IDX_W-1:0];
                  state_in = S_A_FIN;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = {1'b1, 1'b0, rd_q_ff[IDX_W-1:0]};
                  used_in  = used_ff + gran_bytes(e_size);
                  alloc_in = alloc_ff + 32'd1;
                  rsp_in   = '{ffha_pkg::STATUS_DONE, gran_bytes(pos_w + HDR_C),
                               used_in, alloc_in};
                  state_in = S_RESP;
               end
            end else begin
               sum_w    = pos_w + HDR_C + e_size;
               pos_in   = sum_w[PW-1:0];
               state_in = S_A_RD;
            end
         end
         S_A_FIN: begin
            wr_en    = 1'b1;
            wr_data  = {1'b1, 1'b0, bsize_ff};
            used_in  = used_ff + gran_bytes(CW'(bsize_ff));
            alloc_in = alloc_ff + 32'd1;
            rsp_in   = '{ffha_pkg::STATUS_DONE, gran_bytes(pos_w + HDR_C), used_in, alloc_in};
            state_in = S_RESP;
         end
         S_R_RD: begin
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            if (!e_start || e_free) begin
               rsp_in   = '{ffha_pkg::STATUS_IGNORED, 16'd0, used_ff, alloc_ff};
               state_in = S_RESP;
            end else begin
               bsize_in = rd_q_ff[IDX_W-1:0];
               used_in  = used_ff - gran_bytes(e_size);
               state_in = S_N_RD;
            end
         end
         S_N_RD: begin
            // Look at the block that follows the one being released.
            rd_addr = next_w[IDX_W-1:0];
            if (next_w >= GRAN_C) begin
               q_in         = '0;
               have_prev_in = 1'b0;
               state_in     = S_P_RD;
            end else begin
               state_in = S_N_CHK;
            end
         end
         S_N_CHK: begin
            if (e_start && e_free) begin
               sum_w    = CW'(bsize_ff) + HDR_C + e_size;
               bsize_in = sum_w[IDX_W-1:0];
               wr_en    = 1'b1;
               wr_addr  = next_w[IDX_W-1:0];
               wr_data  = '0;
               state_in = S_N_RD;
            end else begin
               q_in         = '0;
               have_prev_in = 1'b0;
               state_in     = S_P_RD;
            end
         end
         S_P_RD: begin
            // Walk from offset zero to find the block just before.
            rd_addr = q_ff[IDX_W-1:0];
            if (q_ff >= pos_ff) begin
               state_in = S_P_END;
            end else begin
               state_in = S_P_CHK;
            end
         end
         S_P_CHK: begin
            if (!e_start) begin
               state_in = S_P_END;
            end else begin
               prev_in      = q_ff;
               prev_size_in = rd_q_ff[IDX_W-1:0];
               prev_free_in = e_free;
               have_prev_in = 1'b1;
               sum_w        = CW'(q_ff) + HDR_C + e_size;
               q_in         = sum_w[PW-1:0];
               state_in     = S_P_RD;
            end
         end
         S_P_END: begin
            wr_en = 1'b1;
            if (have_prev_ff && q_ff == pos_ff && prev_free_ff) begin
               sum_w    = CW'(prev_size_ff) + HDR_C + CW'(bsize_ff);
               wr_addr  = prev_ff[IDX_W-1:0];
               wr_data  = {1'b1, 1'b1, sum_w[IDX_W-1:0]};
               state_in = S_P_CLR;
            end else begin
               wr_data  = {1'b1, 1'b1, bsize_ff};
               rsp_in   = '{ffha_pkg::STATUS_DONE, 16'd0, used_ff, alloc_ff};
               state_in = S_RESP;
            end
         end
         S_P_CLR: begin
            wr_en    = 1'b1;
            wr_data  = '0;
            rsp_in   = '{ffha_pkg::STATUS_DONE, 16'd0, used_ff, alloc_ff};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Block map: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= map_mem[rd_addr];
   end

   // Control state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         have_prev_ff <= 1'b0;
         used_ff      <= '0;
         alloc_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         have_prev_ff <= have_prev_in;
         used_ff      <= used_in;
         alloc_ff     <= alloc_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      pos_ff       <= pos_in;
      need_ff      <= need_in;
      bsize_ff     <= bsize_in;
      q_ff         <= q_in;
      prev_ff      <= prev_in;
      prev_size_ff <= prev_size_in;
      prev_free_ff <= prev_free_in;
      rsp_ff       <= rsp_in;
   end

   // Terms watched by the assertions.
   assign req_fire = req_valid && req_ready;
   assign rsp_oom  = rsp_valid && (rsp_data.status == ffha_pkg::STATUS_OOM);
   assign in_clear = (state_ff == S_CLEAR);

   `FFHA_ASSERT_SAME(a_one_side, clock, reset, req_ready, !rsp_valid, "ready with a response")
   `FFHA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "ready after accept")
   `FFHA_ASSERT_SAME(a_oom_null, clock, reset, rsp_oom, rsp_data.payload_offset == '0, "oom offset")
   `FFHA_ASSERT_SAME(a_clear_busy, clock, reset, in_clear, !req_ready && !rsp_valid, "clear active")

endmodule

// ----- verif/first_fit_heap_allocator_test.sv -----
`timescale 1ns / 100ps

module first_fit_heap_allocator_test;

   localparam int ARENA    = 65536;
   localparam int HDR      = 32;
   localparam int GRAN     = 16;
   localparam int SLOTS    = ARENA / GRAN;
   localparam int RANDOM_REQUESTS = 1200;
   localparam longint CYCLE_LIMIT = 3_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ffha_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ffha_pkg::rsp_type rsp_data;

   first_fit_heap_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the heap layout, one entry per granule.
   bit          blk_start [SLOTS];
   bit          blk_free  [SLOTS];
   int unsigned blk_size  [SLOTS];
   logic [15:0] shadow_used;
   logic [31:0] shadow_allocs;

   ffha_pkg::rsp_type pending_rsp [$];
   int                live_blocks [$];
   int                fail_count = 0;
   longint            cycle_count = 0;
   bit                calm = 1'b0;

   typedef struct {
      ffha_pkg::req_type r;
      bit                typed;
      ffha_pkg::rsp_type e;
   } heap_row_type;

   heap_row_type directed [$];

   function automatic void heap_clear();
      foreach (blk_start[i]) begin
         blk_start[i] = 1'b0;
         blk_free[i]  = 1'b0;
         blk_size[i]  = 0;
      end
      blk_start[0] = 1'b1;
      blk_free[0]  = 1'b1;
      blk_size[0]  = ARENA - HDR;
      shadow_used   = '0;
      shadow_allocs = '0;
   endfunction

   // First fit over the address-ordered chain, splitting off a usable tail.
   function automatic ffha_pkg::rsp_type heap_allocate(logic [15:0] bytes);
      ffha_pkg::rsp_type res;
      int unsigned       want;
      int unsigned       pos;
      int unsigned       idx;
      res = '0;
      res.status = ffha_pkg::STATUS_OOM;
      want = (bytes == 16'd0) ? 32'd1 : 32'(bytes);
      want = (want + GRAN - 1) / GRAN * GRAN;
      pos = 0;
      while (pos < ARENA && blk_start[pos / GRAN]) begin
         idx = pos / GRAN;
         if (blk_free[idx] && blk_size[idx] >= want) begin
            if (blk_size[idx] >= want + HDR + GRAN) begin
               blk_start[(pos + HDR + want) / GRAN] = 1'b1;
               blk_free[(pos + HDR + want) / GRAN]  = 1'b1;
               blk_size[(pos + HDR + want) / GRAN]  = blk_size[idx] - want - HDR;
               blk_size[idx] = want;
            end
            blk_free[idx] = 1'b0;
            shadow_used   = shadow_used + blk_size[idx][15:0];
            shadow_allocs = shadow_allocs + 32'd1;
            res.status = ffha_pkg::STATUS_DONE;
            res.payload_offset = 16'(pos + HDR);
            break;
         end
         pos += HDR + blk_size[idx];
      end
      return res;
   endfunction

   // Free a block, absorb free followers, then fold into a free predecessor.
   function automatic logic [1:0] heap_release(logic [15:0] offset);
      int unsigned pos;
      int unsigned idx;
      int unsigned nxt;
      int unsigned q;
      int unsigned prev;
      bit          have_prev;
      if (offset < HDR) return ffha_pkg::STATUS_IGNORED;
      pos = offset - HDR;
      if (pos % GRAN != 0) return ffha_pkg::STATUS_IGNORED;
      idx = pos / GRAN;
      if (!blk_start[idx] || blk_free[idx]) return ffha_pkg::STATUS_IGNORED;
      blk_free[idx] = 1'b1;
      shadow_used = shadow_used - blk_size[idx][15:0];
      forever begin
         nxt = pos + HDR + blk_size[idx];
         if (nxt >= ARENA) break;
         if (!blk_start[nxt / GRAN] || !blk_free[nxt / GRAN]) break;
         blk_size[idx] += HDR + blk_size[nxt / GRAN];
         blk_start[nxt / GRAN] = 1'b0;
         blk_free[nxt / GRAN]  = 1'b0;
         blk_size[nxt / GRAN]  = 0;
      end
      q = 0;
      prev = 0;
      have_prev = 1'b0;
      while (q < pos && blk_start[q / GRAN]) begin
         prev = q;
         have_prev = 1'b1;
         q += HDR + blk_size[q / GRAN];
      end
      if (have_prev && q == pos && blk_free[prev / GRAN]) begin
         blk_size[prev / GRAN] += HDR + blk_size[idx];
         blk_start[idx] = 1'b0;
         blk_free[idx]  = 1'b0;
         blk_size[idx]  = 0;
      end
      return ffha_pkg::STATUS_DONE;
   endfunction

   function automatic ffha_pkg::rsp_type heap_predict(ffha_pkg::req_type r);
      ffha_pkg::rsp_type res;
      if (r.func == ffha_pkg::FUNC_ALLOC) begin
         res = heap_allocate(r.request_bytes);
      end else begin
         res = '0;
         res.status = heap_release(r.release_offset);
      end
      res.used_bytes  = shadow_used;
      res.alloc_count = shadow_allocs;
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (calm || roll < 45) return 0;
      if (roll < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 60));
   endfunction

   function automatic void add_row(logic f, int bytes, int offset, bit typed,
                                   logic [1:0] st, int pay, int used, int cnt);
      heap_row_type row;
      row.r.func = f;
      row.r.request_bytes = 16'(bytes);
      row.r.release_offset = 16'(offset);
      row.typed = typed;
      row.e.status = st;
      row.e.payload_offset = 16'(pay);
      row.e.used_bytes = 16'(used);
      row.e.alloc_count = 32'(cnt);
      directed.push_back(row);
   endfunction

   // Present one request and hold it until the allocator takes it.
   task automatic send_request(ffha_pkg::req_type r, bit typed, ffha_pkg::rsp_type typed_rsp);
      int                gap;
      ffha_pkg::rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = heap_predict(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      if (r.func == ffha_pkg::FUNC_ALLOC && predicted.status == ffha_pkg::STATUS_DONE)
         live_blocks.push_back(int'(predicted.payload_offset));
   endtask

   // Random request shaped to keep a modest number of live blocks.
   function automatic ffha_pkg::req_type random_request();
      ffha_pkg::req_type r;
      int                roll;
      int                pick;
      bit                do_alloc;
      r.func = ffha_pkg::FUNC_ALLOC;
      r.request_bytes = 16'($urandom());
      r.release_offset = 16'($urandom());
      roll = int'($urandom_range(0, 99));
      if (roll < 10) begin
         r.func = ffha_pkg::FUNC_RELEASE;
         if (roll < 3) r.release_offset = 16'd0;
         return r;
      end
      if (live_blocks.size() < 8) do_alloc = ($urandom_range(0, 9) < 7);
      else if (live_blocks.size() > 40) do_alloc = ($urandom_range(0, 9) < 3);
      else do_alloc = ($urandom_range(0, 1) == 1);
      if (do_alloc || live_blocks.size() == 0) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 75) r.request_bytes = 16'($urandom_range(0, 256));
         else if (roll < 95) r.request_bytes = 16'($urandom_range(257, 4096));
      end else begin
         pick = int'($urandom_range(0, live_blocks.size() - 1));
         r.func = ffha_pkg::FUNC_RELEASE;
         r.release_offset = 16'(live_blocks[pick]);
         live_blocks.delete(pick);
      end
      return r;
   endfunction

   // Response side: random stalls, with calm stretches.
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response with the oldest expected one.
   always @(posedge clock) begin
      ffha_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.payload_offset !== want.payload_offset) begin
               $error("payload_offset: expected %0d, actual %0d",
                      want.payload_offset, rsp_data.payload_offset);
               fail_count++;
            end
            if (rsp_data.used_bytes !== want.used_bytes) begin
               $error("used_bytes: expected %0d, actual %0d",
                      want.used_bytes, rsp_data.used_bytes);
               fail_count++;
            end
            if (rsp_data.alloc_count !== want.alloc_count) begin
               $error("alloc_count: expected %0d, actual %0d",
                      want.alloc_count, rsp_data.alloc_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("first_fit_heap_allocator verification failed");
         $finish;
      end
   end

   initial begin
      heap_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Null, malformed and double releases, zero-byte, oversize and exact-fit allocations.
      add_row(ffha_pkg::FUNC_RELEASE, 16'hFFFF, 0,     1, ffha_pkg::STATUS_IGNORED, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   0,        65535, 1, ffha_pkg::STATUS_DONE,    32, 16, 1);
      add_row(ffha_pkg::FUNC_ALLOC,   65535,    0,     1, ffha_pkg::STATUS_OOM,     0, 16, 1);
      add_row(ffha_pkg::FUNC_RELEASE, 0,        16,    1, ffha_pkg::STATUS_IGNORED, 0, 16, 1);
      add_row(ffha_pkg::FUNC_RELEASE, 0,        33,    1, ffha_pkg::STATUS_IGNORED, 0, 16, 1);
      add_row(ffha_pkg::FUNC_RELEASE, 0,        65535, 1, ffha_pkg::STATUS_IGNORED, 0, 16, 1);
      add_row(ffha_pkg::FUNC_RELEASE, 0,        32,    1, ffha_pkg::STATUS_DONE,    0, 0, 1);
      add_row(ffha_pkg::FUNC_RELEASE, 0,        32,    1, ffha_pkg::STATUS_IGNORED, 0, 0, 1);
      add_row(ffha_pkg::FUNC_ALLOC,   65504,    0,     1, ffha_pkg::STATUS_DONE,    32, 65504, 2);
      add_row(ffha_pkg::FUNC_ALLOC,   1,        0,     1, ffha_pkg::STATUS_OOM,     0, 65504, 2);
      add_row(ffha_pkg::FUNC_RELEASE, 0,        32,    1, ffha_pkg::STATUS_DONE,    0, 0, 2);
      // Splits, middle frees and merges in both directions.
      add_row(ffha_pkg::FUNC_ALLOC,   16,    0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   17,    0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   100,   0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_RELEASE, 0,     80,  0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   32,    0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_RELEASE, 0,     32,  0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_RELEASE, 0,     80,  0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   65,    0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   65344, 0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_ALLOC,   65330, 0,   0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_RELEASE, 0,     128, 0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      add_row(ffha_pkg::FUNC_RELEASE, 0,     32,  0, ffha_pkg::STATUS_DONE, 0, 0, 0);
      foreach (directed[i]) send_request(directed[i].r, directed[i].typed, directed[i].e);
      live_blocks.delete();
      for (int i = 0; i < SLOTS; i++)
         if (blk_start[i] && !blk_free[i]) live_blocks.push_back(i * GRAN + HDR);

      // Hold off until the allocator has answered everything so far.
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         send_request(random_request(), 1'b0, '0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("first_fit_heap_allocator verification clean");
      else
         $display("first_fit_heap_allocator verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/ffha_pkg.sv
src/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_test.sv
